// File: src/fcgi_pkg.sv
// fcgi_pkg: shared types and constants of the record deframer
// request table sizing, status codes, phase codes, table and result structs
// no dependencies
package fcgi_pkg;

   localparam int TABLE_DEPTH = 16;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_BAD_ROLE  = 3'd3;
   localparam logic [2:0] ST_SHORT     = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   localparam logic [7:0]  TYPE_BEGIN    = 8'd1;
   localparam logic [15:0] ROLE_RESPONDER = 16'd1;
   localparam logic [15:0] BEGIN_MIN_LEN  = 16'd8;
   localparam logic [2:0]  HDR_LAST       = 3'd7;

   typedef enum logic [1:0] {
      PH_HEADER = 2'b01,
      PH_BODY   = 2'b10
   } phase_type;

   typedef struct packed {
      logic        insert;
      logic        rel_en;
      logic [15:0] release_id;
      logic [15:0] lookup_id;
   } tbl_cmd_type;

   typedef struct packed {
      logic found;
      logic has_free;
   } tbl_stat_type;

   typedef struct packed {
      logic        content_valid;
      logic [7:0]  content_byte;
      logic [7:0]  record_type;
      logic [15:0] record_id;
      logic        record_done;
      logic [2:0]  status;
   } rsp_item_type;

endpackage

// File: src/fcgi_table.sv
// fcgi_table: bounded table of open request ids with parallel compare
// lookup, lowest-free insert and release; uses fcgi_pkg
module fcgi_table (
   input  logic                 clock,
   input  logic                 reset,
   input  fcgi_pkg::tbl_cmd_type  cmd,
   output fcgi_pkg::tbl_stat_type stat
);
   import fcgi_pkg::*;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [15:0]            id_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] hit, rel_hit, free_oh;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit[i]     = valid_ff[i] && (id_ff[i] == cmd.lookup_id);
         rel_hit[i] = valid_ff[i] && (id_ff[i] == cmd.release_id);
      end
      // lowest clear bit
      free_oh       = ~valid_ff & (valid_ff + TABLE_DEPTH'(1));
      stat.found    = |hit;
      stat.has_free = |(~valid_ff);
   end

   always_comb begin
      priority if (cmd.rel_en) begin
         valid_in = valid_ff & ~rel_hit;
      end else if (cmd.insert) begin
         valid_in = valid_ff | free_oh;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (cmd.insert && free_oh[i]) begin
            id_ff[i] <= cmd.lookup_id;
         end
      end
   end

endmodule

// File: src/fcgi_parse.sv
// fcgi_parse: header collection, record counters and status decision
// drives the request table and forms at most one result per item; uses fcgi_pkg
module fcgi_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_fire,
   input  logic                   item_kind,
   input  logic [7:0]             item_byte,
   input  logic [15:0]            item_release_id,
   output fcgi_pkg::tbl_cmd_type  cmd,
   input  fcgi_pkg::tbl_stat_type stat,
   output logic                   res_valid,
   output fcgi_pkg::rsp_item_type res
);
   import fcgi_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] clen_ff, clen_in;
   logic [7:0]  plen_ff, plen_in;
   logic [16:0] rcnt_ff, rcnt_in;
   logic [15:0] role_ff, role_in;

   logic [16:0] rcnt_inc, total;
   logic [15:0] role_next;
   logic        in_content, finish;

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      type_in    = type_ff;
      id_in      = id_ff;
      clen_in    = clen_ff;
      plen_in    = plen_ff;
      rcnt_in    = rcnt_ff;
      role_in    = role_ff;
      role_next  = role_ff;
      finish     = 1'b0;
      in_content = 1'b0;
      rcnt_inc   = rcnt_ff + 17'd1;
      total      = {1'b0, clen_ff} + {9'd0, plen_ff};

      cmd            = '0;
      cmd.lookup_id  = id_ff;
      cmd.release_id = item_release_id;

      res_valid       = 1'b0;
      res             = '0;
      res.record_type = type_ff;
      res.record_id   = id_ff;

      if (item_fire) begin
         if (item_kind) begin
            cmd.rel_en = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  unique case (hdr_cnt_ff)
                     3'd1:    type_in = item_byte;
                     3'd2:    id_in   = {item_byte, 8'h00};
                     3'd3:    id_in   = {id_ff[15:8], item_byte};
                     3'd4:    clen_in = {item_byte, 8'h00};
                     3'd5:    clen_in = {clen_ff[15:8], item_byte};
                     3'd6:    plen_in = item_byte;
                     default: ;
                  endcase
                  if (hdr_cnt_ff != HDR_LAST) begin
                     hdr_cnt_in = hdr_cnt_ff + 3'd1;
                  end else begin
                     hdr_cnt_in = '0;
                     phase_in   = PH_BODY;
                     rcnt_in    = '0;
                     role_in    = '0;
                     role_next  = '0;
                     if (clen_ff == 16'd0 && plen_ff == 8'd0) begin
                        phase_in  = PH_HEADER;
                        finish    = 1'b1;
                        res_valid = 1'b1;
                     end
                  end
               end
               PH_BODY: begin
                  in_content = rcnt_ff < {1'b0, clen_ff};
                  if (in_content) begin
                     if (rcnt_ff == 17'd0) begin
                        role_next = {item_byte, role_ff[7:0]};
                     end else if (rcnt_ff == 17'd1) begin
                        role_next = {role_ff[15:8], item_byte};
                     end
                  end
                  role_in = role_next;
                  if (rcnt_inc >= total) begin
                     phase_in = PH_HEADER;
                     rcnt_in  = '0;
                     finish   = 1'b1;
                  end else begin
                     rcnt_in = rcnt_inc;
                  end
                  res_valid         = finish || in_content;
                  res.content_valid = in_content;
                  res.content_byte  = in_content ? item_byte : 8'h00;
               end
               default: phase_in = PH_HEADER;
            endcase
         end
      end

      if (finish) begin
         res.record_done = 1'b1;
         priority if (stat.found) begin
            res.status = (type_ff == TYPE_BEGIN) ? ST_DUPLICATE : ST_OK;
         end else if (type_ff != TYPE_BEGIN) begin
            res.status = ST_NOT_FOUND;
         end else if (clen_ff < BEGIN_MIN_LEN) begin
            res.status = ST_SHORT;
         end else if (role_next != ROLE_RESPONDER) begin
            res.status = ST_BAD_ROLE;
         end else if (!stat.has_free) begin
            res.status = ST_FULL;
         end else begin
            res.status = ST_OK;
            cmd.insert = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
         type_ff    <= '0;
         id_ff      <= '0;
         clen_ff    <= '0;
         plen_ff    <= '0;
         rcnt_ff    <= '0;
         role_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         type_ff    <= type_in;
         id_ff      <= id_in;
         clen_ff    <= clen_in;
         plen_ff    <= plen_in;
         rcnt_ff    <= rcnt_in;
         role_ff    <= role_in;
      end
   end

endmodule

// File: src/fastcgi_record_deframer.sv
// fastcgi_record_deframer: top level, input register, parser, table, result register
// uses fcgi_pkg, fcgi_parse and fcgi_table
//
//   channel | ports                                    | direction
//   req     | req_valid req_stall req_kind req_data_byte req_release_id | in
//   rsp     | rsp_valid rsp_stall rsp_content_valid ... rsp_status     | out
//
// one item per cycle while no held result is stalled: the header parse,
// counters and a parallel id compare over the table sit between the input
// register and the result register; items without a result still pass
// reset clears the parser state, both register valids and the table
// req_stall rises only while a held result is stalled and the input register is full
module fastcgi_record_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_release_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_content_valid,
   output logic [7:0]  rsp_content_byte,
   output logic [7:0]  rsp_record_type,
   output logic [15:0] rsp_record_id,
   output logic        rsp_record_done,
   output logic [2:0]  rsp_status
);
   import fcgi_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic         in_kind_ff;
   logic [7:0]   in_byte_ff;
   logic [15:0]  in_rel_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff;

   logic         advance, req_xfer;
   logic         res_valid;
   rsp_item_type res;
   tbl_cmd_type  cmd;
   tbl_stat_type stat;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      priority if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      priority if (advance) begin
         out_valid_in = res_valid;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_data_byte;
         in_rel_ff  <= req_release_id;
      end
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   fcgi_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .item_fire       (advance),
      .item_kind       (in_kind_ff),
      .item_byte       (in_byte_ff),
      .item_release_id (in_rel_ff),
      .cmd             (cmd),
      .stat            (stat),
      .res_valid       (res_valid),
      .res             (res)
   );

   fcgi_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_content_valid = out_ff.content_valid;
   assign rsp_content_byte  = out_ff.content_byte;
   assign rsp_record_type   = out_ff.record_type;
   assign rsp_record_id     = out_ff.record_id;
   assign rsp_record_done   = out_ff.record_done;
   assign rsp_status        = out_ff.status;

endmodule

// File: tb/fcgi_record_checker.sv
`timescale 1ns / 100ps
// fcgi_record_checker: watches both channels of the record deframer, predicts every
// result from the accepted byte stream and compares each result field by field
// depends on fcgi_pkg
module fcgi_record_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_release_id,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_content_valid,
   input  logic [7:0]  rsp_content_byte,
   input  logic [7:0]  rsp_record_type,
   input  logic [15:0] rsp_record_id,
   input  logic        rsp_record_done,
   input  logic [2:0]  rsp_status,
   output int          error_count,
   output int          results_awaited
);
   import fcgi_pkg::*;

   phase_type    parse_phase;
   logic [2:0]   hdr_pos;
   logic [7:0]   hdr_type;
   logic [15:0]  hdr_id;
   logic [15:0]  body_len;
   logic [7:0]   pad_len;
   logic [16:0]  body_pos;
   logic [15:0]  role_word;
   logic         slot_used [TABLE_DEPTH];
   logic [15:0]  slot_id [TABLE_DEPTH];
   rsp_item_type expected_rsp_q [$];

   // table lookup and begin checks at the end of a record
   function automatic logic [2:0] close_record();
      logic       found;
      int         free_slot;
      logic [2:0] st;
      found = 1'b0;
      free_slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_used[i] && slot_id[i] == hdr_id)
            found = 1'b1;
         if (!slot_used[i] && free_slot < 0)
            free_slot = i;
      end
      st = ST_OK;
      if (found) begin
         if (hdr_type == TYPE_BEGIN)
            st = ST_DUPLICATE;
      end else if (hdr_type != TYPE_BEGIN) begin
         st = ST_NOT_FOUND;
      end else if (body_len < BEGIN_MIN_LEN) begin
         st = ST_SHORT;
      end else if (role_word != ROLE_RESPONDER) begin
         st = ST_BAD_ROLE;
      end else if (free_slot < 0) begin
         st = ST_FULL;
      end else begin
         slot_used[free_slot] = 1'b1;
         slot_id[free_slot] = hdr_id;
      end
      return st;
   endfunction

   function automatic void expect_result(logic cv, logic [7:0] b, logic done, logic [2:0] st);
      rsp_item_type r;
      r.content_valid = cv;
      r.content_byte  = cv ? b : 8'h00;
      r.record_type   = hdr_type;
      r.record_id     = hdr_id;
      r.record_done   = done;
      r.status        = done ? st : ST_OK;
      expected_rsp_q.push_back(r);
   endfunction

   task automatic deframe_item(input logic kind, input logic [7:0] b, input logic [15:0] rel);
      logic cv;
      logic done;
      if (kind) begin
         for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_used[i] && slot_id[i] == rel)
               slot_used[i] = 1'b0;
         return;
      end
      if (parse_phase == PH_HEADER) begin
         case (hdr_pos)
            3'd1: hdr_type = b;
            3'd2: hdr_id = {b, 8'h00};
            3'd3: hdr_id[7:0] = b;
            3'd4: body_len = {b, 8'h00};
            3'd5: body_len[7:0] = b;
            3'd6: pad_len = b;
            default: ;
         endcase
         if (hdr_pos != HDR_LAST) begin
            hdr_pos = hdr_pos + 3'd1;
            return;
         end
         hdr_pos = 3'd0;
         parse_phase = PH_BODY;
         body_pos = '0;
         role_word = '0;
         if (body_len == 16'd0 && pad_len == 8'd0) begin
            parse_phase = PH_HEADER;
            expect_result(1'b0, 8'h00, 1'b1, close_record());
         end
         return;
      end
      cv = body_pos < {1'b0, body_len};
      if (cv) begin
         if (body_pos == 17'd0)
            role_word[15:8] = b;
         else if (body_pos == 17'd1)
            role_word[7:0] = b;
      end
      body_pos = body_pos + 17'd1;
      done = body_pos >= ({1'b0, body_len} + {9'd0, pad_len});
      if (done) begin
         parse_phase = PH_HEADER;
         body_pos = '0;
         expect_result(cv, b, 1'b1, close_record());
      end else if (cv) begin
         expect_result(1'b1, b, 1'b0, ST_OK);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t rsp_%s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         parse_phase = PH_HEADER;
         hdr_pos = '0;
         hdr_type = '0;
         hdr_id = '0;
         body_len = '0;
         pad_len = '0;
         body_pos = '0;
         role_word = '0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_used[i] = 1'b0;
            slot_id[i] = '0;
         end
         expected_rsp_q.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               error_count++;
               $display("%0t unexpected result: expected none, actual %h", $time,
                        {rsp_content_valid, rsp_content_byte, rsp_record_type,
                         rsp_record_id, rsp_record_done, rsp_status});
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("content_valid", want.content_valid, rsp_content_valid);
               check_field("content_byte", want.content_byte, rsp_content_byte);
               check_field("record_type", want.record_type, rsp_record_type);
               check_field("record_id", want.record_id, rsp_record_id);
               check_field("record_done", want.record_done, rsp_record_done);
               check_field("status", want.status, rsp_status);
            end
         end
         if (req_valid && !req_stall)
            deframe_item(req_kind, req_data_byte, req_release_id);
      end
      results_awaited <= expected_rsp_q.size();
   end

endmodule

// File: tb/tb_fastcgi_record_deframer.sv
`timescale 1ns / 100ps
// tb_fastcgi_record_deframer: drives record streams and id releases into the deframer
// with random idling and a long result hold-off; depends on fcgi_pkg, the block and
// fcgi_record_checker, which reports the failure count used for the verdict
module tb_fastcgi_record_deframer;
   import fcgi_pkg::*;

   localparam int ITEM_TARGET       = 1900;
   localparam int RELEASE_FROM      = 600;
   localparam int BIG_RECORD_AT     = 1200;
   localparam int IDLE_PCT          = 10;
   localparam int SENDER_CALM_FIRST = 300;
   localparam int SENDER_CALM_LAST  = 700;
   localparam int HOLD_START        = 1000;
   localparam int HOLD_LEN          = 300;
   localparam int RX_CALM_FIRST     = 1800;
   localparam int RX_CALM_LAST      = 2200;
   localparam int DRAIN_CYCLES      = 10;
   localparam int RUN_LIMIT         = 100000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic [15:0] req_release_id = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_content_valid;
   logic [7:0]  rsp_content_byte;
   logic [7:0]  rsp_record_type;
   logic [15:0] rsp_record_id;
   logic        rsp_record_done;
   logic [2:0]  rsp_status;

   int items_sent = 0;
   int rx_cycle = 0;
   int run_cycles = 0;
   int error_count;
   int results_awaited;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fastcgi_record_deframer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_data_byte     (req_data_byte),
      .req_release_id    (req_release_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_content_valid (rsp_content_valid),
      .rsp_content_byte  (rsp_content_byte),
      .rsp_record_type   (rsp_record_type),
      .rsp_record_id     (rsp_record_id),
      .rsp_record_done   (rsp_record_done),
      .rsp_status        (rsp_status)
   );

   fcgi_record_checker watcher (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_data_byte     (req_data_byte),
      .req_release_id    (req_release_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_content_valid (rsp_content_valid),
      .rsp_content_byte  (rsp_content_byte),
      .rsp_record_type   (rsp_record_type),
      .rsp_record_id     (rsp_record_id),
      .rsp_record_done   (rsp_record_done),
      .rsp_status        (rsp_status),
      .error_count       (error_count),
      .results_awaited   (results_awaited)
   );

   // receiver: random stalls, one long hold-off, one calm stretch
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
         rsp_stall <= 1'b1;
      else if (rx_cycle >= RX_CALM_FIRST && rx_cycle < RX_CALM_LAST)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      run_cycles <= run_cycles + 1;
      if (run_cycles == RUN_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [15:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return 16'hFFFF;
      if (r < 10)
         return 16'h0000;
      if (r < 92)
         return 16'($urandom_range(1, 18));
      return 16'($urandom);
   endfunction

   task automatic send_item(input logic kind, input logic [7:0] b, input logic [15:0] rel);
      while (!(items_sent >= SENDER_CALM_FIRST && items_sent < SENDER_CALM_LAST)
             && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_data_byte <= b;
      req_release_id <= rel;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   // stream byte, now and then followed by a release in the middle of a record
   task automatic send_byte(input logic [7:0] b);
      send_item(1'b0, b, 16'($urandom));
      if (items_sent >= RELEASE_FROM && $urandom_range(0, 99) == 0)
         send_item(1'b1, 8'($urandom), pick_id());
   endtask

   task automatic send_record(input logic [7:0] rtype, input logic [15:0] rid,
                              input int clen, input int plen, input logic [15:0] role);
      send_byte(8'($urandom));
      send_byte(rtype);
      send_byte(rid[15:8]);
      send_byte(rid[7:0]);
      send_byte(8'(clen >> 8));
      send_byte(8'(clen));
      send_byte(8'(plen));
      send_byte(8'($urandom));
      for (int i = 0; i < clen; i++)
         send_byte(i == 0 ? role[15:8] : i == 1 ? role[7:0] : 8'($urandom));
      for (int i = 0; i < plen; i++)
         send_byte(8'($urandom));
   endtask

   initial begin : stimulus
      int         pick;
      int         shape;
      int         clen;
      int         plen;
      logic [15:0] role;
      logic [7:0] rtype;
      bit         big_done;
      big_done = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // no body, unknown id
      send_record(8'hFF, 16'hFFFF, 0, 0, 16'h0000);
      send_record(TYPE_BEGIN, 16'h0000, 8, 0, ROLE_RESPONDER);
      // duplicate begin, record ends on padding
      send_record(TYPE_BEGIN, 16'h0000, 8, 2, ROLE_RESPONDER);
      send_record(8'h00, 16'h0000, 3, 0, 16'hFFFF);
      send_record(TYPE_BEGIN, 16'h1234, 7, 1, ROLE_RESPONDER);
      send_record(TYPE_BEGIN, 16'h1234, 8, 0, 16'h0100);
      // begin with partial role, then begin without body
      send_record(TYPE_BEGIN, 16'h00FF, 1, 0, ROLE_RESPONDER);
      send_record(TYPE_BEGIN, 16'h8000, 0, 0, ROLE_RESPONDER);
      send_item(1'b1, 8'h00, 16'h0000);
      send_item(1'b1, 8'hFF, 16'hABCD);
      send_record(8'h05, 16'h0000, 0, 5, 16'h0000);

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (!big_done && items_sent >= BIG_RECORD_AT) begin
            big_done = 1'b1;
            send_record(TYPE_BEGIN, pick_id(), 257, 255, ROLE_RESPONDER);
         end else if (pick < 45) begin
            shape = $urandom_range(0, 9);
            clen = (shape == 8) ? $urandom_range(0, 7) : $urandom_range(8, 12);
            role = (shape == 9) ? 16'($urandom) : ROLE_RESPONDER;
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
            send_record(TYPE_BEGIN, pick_id(), clen, plen, role);
         end else if (pick < 95 || items_sent < RELEASE_FROM) begin
            rtype = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(2, 11));
            send_record(rtype, pick_id(), $urandom_range(0, 6), $urandom_range(0, 3),
                        16'($urandom));
         end else begin
            send_item(1'b1, 8'($urandom), pick_id());
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (results_awaited != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
